[design/rbsi_pkg.sv]
// rbsi_pkg: shared constants and types for the ray/box slab intersection block.
// No dependencies; compile first.
`default_nettype none

package rbsi_pkg;

    localparam int DEF_COORD_WIDTH = 32;
    localparam int DEF_FRAC_BITS   = 16;

    // configuration index: one spare bit so writes past the last register exist (ignored)
    localparam int CFG_IDX_W = 4;

    // pipeline depth of one lane (subtract, product split, two sums, scale) and of the merge
    localparam int LANE_LAT  = 5;
    localparam int MERGE_LAT = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X  = 4'd0,
        REG_ORIGIN_Y  = 4'd1,
        REG_ORIGIN_Z  = 4'd2,
        REG_INV_DIR_X = 4'd3,
        REG_INV_DIR_Y = 4'd4,
        REG_INV_DIR_Z = 4'd5,
        REG_DIST_MIN  = 4'd6,
        REG_DIST_MAX  = 4'd7
    } t_cfg_reg;

endpackage

`default_nettype wire

[design/rbsi_if.sv]
// rbsi_if: valid/ready channel interfaces for boxes in, hit results out, and config writes.
// Depends on rbsi_pkg.
`default_nettype none

interface rbsi_box_if import rbsi_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] box_min_x;
    logic signed [COORD_WIDTH-1:0] box_min_y;
    logic signed [COORD_WIDTH-1:0] box_min_z;
    logic signed [COORD_WIDTH-1:0] box_max_x;
    logic signed [COORD_WIDTH-1:0] box_max_y;
    logic signed [COORD_WIDTH-1:0] box_max_z;

    modport source (output valid, box_min_x, box_min_y, box_min_z,
                    box_max_x, box_max_y, box_max_z, input ready);
    modport sink   (input valid, box_min_x, box_min_y, box_min_z,
                    box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface rbsi_hit_if import rbsi_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] entry_dist;
    logic signed [COORD_WIDTH-1:0] exit_dist;

    modport source (output valid, hit, entry_dist, exit_dist, input ready);
    modport sink   (input valid, hit, entry_dist, exit_dist, output ready);
endinterface

interface rbsi_cfg_if import rbsi_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic [CFG_IDX_W-1:0]          index;
    logic [COORD_WIDTH-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/rbsi_slab_mul.sv]
// rbsi_slab_mul: pipelined (plane - origin) * inv_dir, scaled down with floor and saturated.
// Four stages: partial products, middle sum, full sum, shift/saturate. No package use.
`default_nettype none

module rbsi_slab_mul #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH:0]   i_diff,
    input  logic signed [COORD_WIDTH-1:0] i_inv,
    output logic signed [COORD_WIDTH-1:0] o_dist
);

    localparam int CW  = COORD_WIDTH;
    localparam int H   = CW / 2;
    localparam int DHW = CW + 1 - H;
    localparam int IHW = CW - H;
    localparam int PW  = 2 * CW + 1;

    // operand halves: low halves unsigned, high halves signed
    logic        [H-1:0]        w_dl;
    logic signed [DHW-1:0]      w_dh;
    logic        [H-1:0]        w_il;
    logic signed [IHW-1:0]      w_ih;

    logic        [2*H-1:0]      r_ll;
    logic signed [DHW+H:0]      r_lh;
    logic signed [H+IHW:0]      r_hl;
    logic signed [DHW+IHW-1:0]  r_hh;

    logic        [2*H-1:0]      r_ll2;
    logic signed [DHW+IHW-1:0]  r_hh2;
    logic signed [PW-1:0]       r_mid;

    logic signed [PW-1:0]       r_prod;
    logic signed [PW-1:0]       w_q;
    logic                       w_fit;
    logic signed [CW-1:0]       r_dist;

    assign w_dl = i_diff[H-1:0];
    assign w_dh = $signed(i_diff[CW:H]);
    assign w_il = i_inv[H-1:0];
    assign w_ih = $signed(i_inv[CW-1:H]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll  <= w_dl * w_il;
            r_lh  <= w_dh * $signed({1'b0, w_il});
            r_hl  <= $signed({1'b0, w_dl}) * w_ih;
            r_hh  <= w_dh * w_ih;

            r_ll2 <= r_ll;
            r_hh2 <= r_hh;
            r_mid <= PW'(r_lh) + PW'(r_hl);

            r_prod <= (PW'(r_hh2) <<< (2 * H)) + (r_mid <<< H) + PW'(r_ll2);

            r_dist <= w_fit ? w_q[CW-1:0]
                            : (w_q[PW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});
        end
    end

    // arithmetic shift of the exact product rounds toward minus infinity
    assign w_q   = r_prod >>> FRAC_BITS;
    assign w_fit = (&w_q[PW-1:CW-1]) || !(|w_q[PW-1:CW-1]);

    assign o_dist = r_dist;

endmodule

`default_nettype wire

[design/rbsi_lane.sv]
// rbsi_lane: one axis of the slab test; picks near/far planes and computes both distances.
// Depends on rbsi_slab_mul.
`default_nettype none

module rbsi_lane #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_lo,
    input  logic signed [COORD_WIDTH-1:0] i_hi,
    input  logic signed [COORD_WIDTH-1:0] i_org,
    input  logic signed [COORD_WIDTH-1:0] i_inv,
    output logic signed [COORD_WIDTH-1:0] o_near,
    output logic signed [COORD_WIDTH-1:0] o_far
);

    localparam int CW = COORD_WIDTH;

    logic signed [CW:0]   w_d_lo;
    logic signed [CW:0]   w_d_hi;
    logic                 w_pos;
    logic signed [CW:0]   r_dn;
    logic signed [CW:0]   r_df;
    logic signed [CW-1:0] r_inv;

    // exact differences, one bit wider than the coordinates
    assign w_d_lo = (CW+1)'(i_lo) - (CW+1)'(i_org);
    assign w_d_hi = (CW+1)'(i_hi) - (CW+1)'(i_org);
    assign w_pos  = !i_inv[CW-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dn  <= w_pos ? w_d_lo : w_d_hi;
            r_df  <= w_pos ? w_d_hi : w_d_lo;
            r_inv <= i_inv;
        end
    end

    rbsi_slab_mul #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_near (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_diff (r_dn),
        .i_inv  (r_inv),
        .o_dist (o_near)
    );

    rbsi_slab_mul #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_far (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_diff (r_df),
        .i_inv  (r_inv),
        .o_dist (o_far)
    );

endmodule

`default_nettype wire

[design/rbsi_merge.sv]
// rbsi_merge: combines the three axis intervals with early rejection, then tests the ray range.
// Three register stages. No package use.
`default_nettype none

module rbsi_merge #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_near_x,
    input  logic signed [COORD_WIDTH-1:0] i_far_x,
    input  logic signed [COORD_WIDTH-1:0] i_near_y,
    input  logic signed [COORD_WIDTH-1:0] i_far_y,
    input  logic signed [COORD_WIDTH-1:0] i_near_z,
    input  logic signed [COORD_WIDTH-1:0] i_far_z,
    input  logic signed [COORD_WIDTH-1:0] i_dist_min,
    input  logic signed [COORD_WIDTH-1:0] i_dist_max,
    output logic                          o_hit,
    output logic signed [COORD_WIDTH-1:0] o_entry,
    output logic signed [COORD_WIDTH-1:0] o_exit
);

    localparam int CW = COORD_WIDTH;
    localparam logic signed [CW-1:0] MAX_POS = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MIN_NEG = {1'b1, {(CW-1){1'b0}}};

    // stage 1: x/y
    logic                 r_rej1;
    logic signed [CW-1:0] r_ent1, r_ext1, r_nz1, r_fz1;
    // stage 2: z
    logic                 r_rej2;
    logic signed [CW-1:0] r_ent2, r_ext2;
    // stage 3: ray range and miss encoding
    logic                 r_hit;
    logic signed [CW-1:0] r_entry, r_exit;
    logic                 w_hit;

    assign w_hit = !r_rej2 && (r_ent2 < i_dist_max) && (i_dist_min < r_ext2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rej1 <= (i_far_y < i_near_x) || (i_far_x < i_near_y);
            r_ent1 <= (i_near_x < i_near_y) ? i_near_y : i_near_x;
            r_ext1 <= (i_far_y < i_far_x) ? i_far_y : i_far_x;
            r_nz1  <= i_near_z;
            r_fz1  <= i_far_z;

            r_rej2 <= r_rej1 || (r_fz1 < r_ent1) || (r_ext1 < r_nz1);
            r_ent2 <= (r_ent1 < r_nz1) ? r_nz1 : r_ent1;
            r_ext2 <= (r_fz1 < r_ext1) ? r_fz1 : r_ext1;

            r_hit   <= w_hit;
            r_entry <= w_hit ? r_ent2 : MAX_POS;
            r_exit  <= w_hit ? r_ext2 : MIN_NEG;
        end
    end

    assign o_hit   = r_hit;
    assign o_entry = r_entry;
    assign o_exit  = r_exit;

endmodule

`default_nettype wire

[design/ray_box_slab_intersect.sv]
// ray_box_slab_intersect: slab test of one configured ray against a stream of boxes.
// Depends on rbsi_pkg, rbsi_if, rbsi_lane, rbsi_merge.
//
// Usage:
//   i_cfg  - register writes (index per t_cfg_reg, data). Always ready. Write only while
//            no box is in flight. Indexes past the last register are dropped.
//   i_box  - one box (min and max corners) per transfer.
//   o_hit  - one result per box, in order: hit flag, entry and exit distance. A miss
//            returns entry = most positive, exit = most negative.
// Throughput: one box per cycle, sustained while the output does not stall. Three lanes
// (x, y, z), each with two pipelined split multipliers, feed a three-stage merge.
// From the box transfer to o_hit.valid a box passes 5 lane stages, 3 merge stages
// and the output register.
// Stall: an output register plus one skid entry sit behind the pipeline. While a result
// waits in the output register boxes are still taken; once the skid entry fills,
// i_box.ready drops and the whole pipeline holds until the receiver takes a result.
// Reset (synchronous, active low): pipeline and output empty; ray = origin 0,
// inv_dir 1.0, distance range [0, most positive].
`default_nettype none

module ray_box_slab_intersect import rbsi_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbsi_cfg_if.sink   i_cfg,
    rbsi_box_if.sink   i_box,
    rbsi_hit_if.source o_hit
);

    localparam int CW  = COORD_WIDTH;
    localparam int LAT = LANE_LAT + MERGE_LAT;
    localparam logic signed [CW-1:0] MAX_POS = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MIN_NEG = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE_FX  = {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;

    // ray registers, per axis
    logic signed [CW-1:0] r_org [3];
    logic signed [CW-1:0] r_inv [3];
    logic signed [CW-1:0] r_dist_min;
    logic signed [CW-1:0] r_dist_max;

    logic signed [CW-1:0] w_lo   [3];
    logic signed [CW-1:0] w_hi   [3];
    logic signed [CW-1:0] w_near [3];
    logic signed [CW-1:0] w_far  [3];

    logic                 w_en;
    logic [LAT-1:0]       r_vld;
    logic                 w_m_hit;
    logic signed [CW-1:0] w_m_entry, w_m_exit;

    logic                 r_out_v, r_skd_v;
    logic                 r_out_hit, r_skd_hit;
    logic signed [CW-1:0] r_out_entry, r_out_exit, r_skd_entry, r_skd_exit;
    logic                 w_push, w_pop;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0]   <= '0;
            r_org[1]   <= '0;
            r_org[2]   <= '0;
            r_inv[0]   <= ONE_FX;
            r_inv[1]   <= ONE_FX;
            r_inv[2]   <= ONE_FX;
            r_dist_min <= '0;
            r_dist_max <= MAX_POS;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_ORIGIN_X:  r_org[0]   <= i_cfg.data;
                REG_ORIGIN_Y:  r_org[1]   <= i_cfg.data;
                REG_ORIGIN_Z:  r_org[2]   <= i_cfg.data;
                REG_INV_DIR_X: r_inv[0]   <= i_cfg.data;
                REG_INV_DIR_Y: r_inv[1]   <= i_cfg.data;
                REG_INV_DIR_Z: r_inv[2]   <= i_cfg.data;
                REG_DIST_MIN:  r_dist_min <= i_cfg.data;
                REG_DIST_MAX:  r_dist_max <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // pipeline advances unless the skid entry is occupied
    assign w_en        = !r_skd_v;
    assign i_box.ready = w_en;

    assign w_lo[0] = i_box.box_min_x;
    assign w_lo[1] = i_box.box_min_y;
    assign w_lo[2] = i_box.box_min_z;
    assign w_hi[0] = i_box.box_max_x;
    assign w_hi[1] = i_box.box_max_y;
    assign w_hi[2] = i_box.box_max_z;

    for (genvar a = 0; a < 3; a++) begin : g_lane
        rbsi_lane #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_lo   (w_lo[a]),
            .i_hi   (w_hi[a]),
            .i_org  (r_org[a]),
            .i_inv  (r_inv[a]),
            .o_near (w_near[a]),
            .o_far  (w_far[a])
        );
    end

    rbsi_merge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_merge (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_near_x   (w_near[0]),
        .i_far_x    (w_far[0]),
        .i_near_y   (w_near[1]),
        .i_far_y    (w_far[1]),
        .i_near_z   (w_near[2]),
        .i_far_z    (w_far[2]),
        .i_dist_min (r_dist_min),
        .i_dist_max (r_dist_max),
        .o_hit      (w_m_hit),
        .o_entry    (w_m_entry),
        .o_exit     (w_m_exit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_box.valid};
        end
    end

    // output register with one skid entry
    assign w_push = w_en && r_vld[LAT-1];
    assign w_pop  = r_out_v && o_hit.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (r_skd_v) begin
            if (w_pop) begin
                r_skd_v <= 1'b0;
            end
        end else if (w_push) begin
            if (r_out_v && !w_pop) begin
                r_skd_v <= 1'b1;
            end
            r_out_v <= 1'b1;
        end else if (w_pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_v) begin
            if (w_pop) begin
                r_out_hit   <= r_skd_hit;
                r_out_entry <= r_skd_entry;
                r_out_exit  <= r_skd_exit;
            end
        end else if (w_push) begin
            if (r_out_v && !w_pop) begin
                r_skd_hit   <= w_m_hit;
                r_skd_entry <= w_m_entry;
                r_skd_exit  <= w_m_exit;
            end else begin
                r_out_hit   <= w_m_hit;
                r_out_entry <= w_m_entry;
                r_out_exit  <= w_m_exit;
            end
        end
    end

    assign o_hit.valid      = r_out_v;
    assign o_hit.hit        = r_out_hit;
    assign o_hit.entry_dist = r_out_entry;
    assign o_hit.exit_dist  = r_out_exit;

    // skid entry only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_v |-> r_out_v)
        else $error("skid entry valid with empty output register");

    // no box taken while the skid entry is full
    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_v |-> !(i_box.valid && i_box.ready))
        else $error("box transfer while pipeline is held");

    // a miss always carries the empty interval
    a_miss_encoding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hit.valid && !o_hit.hit) |-> (o_hit.entry_dist == MAX_POS && o_hit.exit_dist == MIN_NEG))
        else $error("miss result with non-empty interval");

    // a stalled result that is refused stays in place
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !o_hit.ready) |=> (r_out_v && $stable(r_out_entry) && $stable(r_out_exit)))
        else $error("held result changed");

endmodule

`default_nettype wire
